[rtl/thermistor_linearize_scan_stats_top_macros.svh]
// assertion macros for the thermistor linearizer
`ifndef THERMISTOR_LINEARIZE_SCAN_STATS_TOP_MACROS_SVH
`define THERMISTOR_LINEARIZE_SCAN_STATS_TOP_MACROS_SVH
`define TLS_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("%m: lbl failed");
`define TLS_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("%m: lbl failed");
`endif

[rtl/tls_pkg.sv]
// package with table, register codes and shared types for the thermistor linearizer
package tls_pkg;
   localparam int TPTS = 33;
   localparam logic [1:0] CSR_VVL = 2'd0;
   localparam logic [1:0] CSR_VVH = 2'd1;
   localparam logic [1:0] CSR_ITL = 2'd2;
   localparam logic [1:0] CSR_ITH = 2'd3;
   localparam logic signed [16:0] NODE0_TEMP = 17'sd30720;
   localparam logic signed [16:0] NODE_STEP = 17'sd1280;
   localparam logic [6:0] COUNT_MAX = 7'd127;
   typedef logic signed [15:0] temp_type;

   function automatic logic [13:0] vk(input logic [5:0] k);
      logic [13:0] t [0:TPTS-1];
      t = '{14'd4160, 14'd4192, 14'd4224, 14'd4256, 14'd4288, 14'd4320, 14'd4384,
            14'd4416, 14'd4480, 14'd4576, 14'd4640, 14'd4736, 14'd4832, 14'd4960,
            14'd5088, 14'd5216, 14'd5376, 14'd5568, 14'd5760, 14'd5952, 14'd6144,
            14'd6368, 14'd6560, 14'd6752, 14'd6944, 14'd7136, 14'd7264, 14'd7424,
            14'd7520, 14'd7616, 14'd7680, 14'd7744, 14'd7808};
      return (k < 6'(TPTS)) ? t[k] : t[TPTS-1];
   endfunction

   // 2^20 / (2 * m) rounded up, exact quotient for numerators below 2^15
   function automatic logic [19:0] half_recip(input logic [2:0] m);
      logic [19:0] r;
      unique case (m)
         3'd1: r = 20'd524288;
         3'd2: r = 20'd262144;
         3'd3: r = 20'd174763;
         3'd4: r = 20'd131072;
         3'd5: r = 20'd104858;
         3'd6: r = 20'd87382;
         3'd7: r = 20'd74899;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

[rtl/thermistor_linearize_scan_stats_top.sv]
// top level: thermistor linearizer with per-scan min, max and average
// flow: accepted samples pass the read, multiply, interpolate and write states in order;
// on a last_of_scan sample with a nonzero valid count the average divider runs before the result
// throughput: one transaction at a time, the next accepted once the result is taken
// reset: registers and running statistics take reset values, then a clearing pass over all
// NUM_CHANNELS entries zeroes the temperature memory before any sample is taken
`include "thermistor_linearize_scan_stats_top_macros.svh"
module thermistor_linearize_scan_stats_top
   import tls_pkg::*;
#(
   parameter int NUM_CHANNELS = 88
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [6:0]         req_channel_index,
   input  logic [15:0]        req_adc_code,
   input  logic               req_last_of_scan,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_temperature,
   output logic               rsp_reading_held,
   output logic               rsp_channel_ignored,
   output logic               rsp_scan_done,
   output logic signed [15:0] rsp_scan_min,
   output logic signed [15:0] rsp_scan_max,
   output logic signed [15:0] rsp_scan_average,
   output logic [6:0]         rsp_valid_count,
   output logic [6:0]         rsp_ignored_count,
   output logic               rsp_no_valid_channels,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_RD = 3'd2, ST_INT = 3'd3,
                          ST_WR = 3'd4, ST_DIV = 3'd5, ST_MUL = 3'd6;

   logic [2:0] st_ff, st_in;
   logic [AW:0] clr_ff, clr_in;
   temp_type vvl_ff, vvh_ff, itl_ff, ith_ff;
   temp_type mem [0:NUM_CHANNELS-1];
   temp_type rd_ff;
   logic [6:0] ch_ff;
   logic signed [16:0] v_ff;
   logic last_ff, have_ff;
   temp_type rmin_ff, rmax_ff;
   logic signed [23:0] rsum_ff;
   logic [6:0] ucnt_ff, scnt_ff;
   // interpolation stages
   logic [5:0] seg, seg_ff;
   logic [13:0] lo, hi, d;
   logic [7:0] x;
   logic [2:0] m, m_ff;
   logic [14:0] n_ff;
   logic clo_ff, chi_ff;
   logic [34:0] prod;
   logic [10:0] drop;
   logic signed [16:0] lin;
   temp_type lin_ff;
   logic held_ff;
   temp_type t;
   logic ign;
   logic div_start, div_busy, div_done;
   temp_type quo;
   logic o_valid_ff;
   temp_type o_t_ff, o_min_ff, o_max_ff, o_avg_ff;
   logic o_held_ff, o_ign_ff, o_done_ff, o_empty_ff;
   logic [6:0] o_uc_ff, o_sc_ff;
   logic mem_we;
   logic [AW-1:0] mem_wa;
   temp_type mem_wd;

   assign csr_ready = 1'b1;
   assign req_ready = (st_ff == ST_IDLE) && !o_valid_ff;

   // segment search and offset into the segment
   always_comb begin
      seg = 6'd0;
      for (int k = 0; k < TPTS - 1; k++)
         if (v_ff >= $signed({3'b0, vk(6'(k))})) seg = 6'(k);
      lo = vk(seg);
      hi = vk(seg + 6'd1);
      d = hi - lo;
      m = d[7:5];
      x = 8'(v_ff - $signed({3'b0, lo}));
   end

   // rounded drop within the segment by reciprocal multiplication
   always_comb begin
      prod = 35'(n_ff) * 35'(half_recip(m_ff));
      drop = 11'(prod >> 20);
      if (clo_ff)
         lin = NODE0_TEMP;
      else if (chi_ff)
         lin = NODE0_TEMP - NODE_STEP * 17'(TPTS - 1);
      else
         lin = NODE0_TEMP - NODE_STEP * $signed({11'b0, seg_ff}) - $signed({6'b0, drop});
   end

   assign t = held_ff ? (have_ff ? rd_ff : '0) : lin_ff;
   assign ign = (t < itl_ff) || (t > ith_ff);
   assign div_start = (st_ff == ST_WR) && last_ff && (ucnt_ff != 7'd0);

   tls_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(rsum_ff), .divisor(ucnt_ff),
      .busy(div_busy), .done(div_done), .quotient(quo)
   );

   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      unique case (st_ff)
         ST_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(NUM_CHANNELS - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: if (req_valid && req_ready) st_in = ST_RD;
         ST_RD:   st_in = ST_MUL;
         ST_MUL:  st_in = ST_INT;
         ST_INT:  st_in = ST_WR;
         ST_WR:   st_in = div_start ? ST_DIV : ST_IDLE;
         ST_DIV:  if (div_done) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_ff[AW-1:0];
      mem_wd = '0;
      if (st_ff == ST_CLR) mem_we = 1'b1;
      else if (st_ff == ST_WR && have_ff) begin
         mem_we = 1'b1;
         mem_wa = ch_ff[AW-1:0];
         mem_wd = t;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (st_ff == ST_IDLE) rd_ff <= mem[req_channel_index[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLR;
         clr_ff <= '0;
         vvl_ff <= -16'sd640;
         vvh_ff <= 16'sd11200;
         itl_ff <= -16'sd9984;
         ith_ff <= 16'sd30464;
         rmin_ff <= 16'sd30464;
         rmax_ff <= -16'sd9984;
         rsum_ff <= '0;
         ucnt_ff <= '0;
         scnt_ff <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_VVL: vvl_ff <= csr_data;
               CSR_VVH: vvh_ff <= csr_data;
               CSR_ITL: itl_ff <= csr_data;
               CSR_ITH: ith_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) o_valid_ff <= 1'b0;
         if (st_ff == ST_IDLE && req_valid && req_ready) begin
            ch_ff <= req_channel_index;
            v_ff <= $signed({1'b0, req_adc_code}) - 17'sd32768;
            last_ff <= req_last_of_scan;
            have_ff <= 32'(req_channel_index) < NUM_CHANNELS;
         end
         if (st_ff == ST_RD) begin
            seg_ff <= seg;
            m_ff <= m;
            n_ff <= 15'(x) * 15'd80 + 15'(m);
            clo_ff <= v_ff < $signed(17'(vk(6'd0)));
            chi_ff <= v_ff > $signed(17'(vk(6'(TPTS - 1))));
            held_ff <= (v_ff < 17'(vvl_ff)) || (v_ff > 17'(vvh_ff));
         end
         if (st_ff == ST_MUL) begin
            lin_ff <= lin[15:0];
         end
         if (st_ff == ST_INT) begin
            if (ign) begin
               if (scnt_ff != COUNT_MAX) scnt_ff <= scnt_ff + 7'd1;
            end else if (ucnt_ff != COUNT_MAX) begin
               rsum_ff <= rsum_ff + 24'(t);
               ucnt_ff <= ucnt_ff + 7'd1;
            end
         end
         if (st_ff == ST_WR) begin
            o_t_ff <= t;
            o_held_ff <= held_ff;
            o_ign_ff <= ign;
            o_done_ff <= last_ff;
            o_avg_ff <= '0;
            if (last_ff) begin
               o_min_ff <= (!ign && t < rmin_ff) ? t : rmin_ff;
               o_max_ff <= (!ign && t > rmax_ff) ? t : rmax_ff;
               o_uc_ff <= ucnt_ff;
               o_sc_ff <= scnt_ff;
               o_empty_ff <= (ucnt_ff == 7'd0);
               if (ucnt_ff == 7'd0) begin
                  o_valid_ff <= 1'b1;
                  rsum_ff <= '0;
               end
               rmin_ff <= ith_ff;
               rmax_ff <= itl_ff;
               scnt_ff <= '0;
            end else begin
               o_min_ff <= '0;
               o_max_ff <= '0;
               o_uc_ff <= '0;
               o_sc_ff <= '0;
               o_empty_ff <= 1'b0;
               o_valid_ff <= 1'b1;
               if (!ign) begin
                  if (t < rmin_ff) rmin_ff <= t;
                  if (t > rmax_ff) rmax_ff <= t;
               end
            end
         end
         if (div_done) begin
            o_avg_ff <= quo;
            o_valid_ff <= 1'b1;
            rsum_ff <= '0;
            ucnt_ff <= '0;
         end
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_temperature = o_t_ff;
   assign rsp_reading_held = o_held_ff;
   assign rsp_channel_ignored = o_ign_ff;
   assign rsp_scan_done = o_done_ff;
   assign rsp_scan_min = o_min_ff;
   assign rsp_scan_max = o_max_ff;
   assign rsp_scan_average = o_avg_ff;
   assign rsp_valid_count = o_uc_ff;
   assign rsp_ignored_count = o_sc_ff;
   assign rsp_no_valid_channels = o_empty_ff;

   `TLS_ASSERT_IMPL(a_no_req_in_clear, clock, reset, st_ff == ST_CLR, !req_ready)
   `TLS_ASSERT_IMPL(a_div_only_in_div, clock, reset, div_busy, st_ff == ST_DIV)
   `TLS_ASSERT_NEXT(a_rd_follows_accept, clock, reset, req_valid && req_ready, st_ff == ST_RD)
endmodule

[rtl/tls_div.sv]
// restoring divider for the scan average, one quotient bit per cycle
module tls_div
   import tls_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [23:0] dividend,
   input  logic [6:0]         divisor,
   output logic               busy,
   output logic               done,
   output logic signed [15:0] quotient
);
   logic [23:0] mag_ff, mag_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [7:0]  trial;
   logic [23:0] qs;

   always_comb begin
      mag_in = mag_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, mag_ff[23]};
      if (start) begin
         mag_in = dividend[23] ? 24'(-dividend) : dividend;
         neg_in = dividend[23];
         dvs_in = divisor;
         rem_in = '0;
         cnt_in = 5'd24;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 7'(trial - {1'b0, dvs_ff});
            mag_in = {mag_ff[22:0], 1'b1};
         end else begin
            rem_in = trial[6:0];
            mag_in = {mag_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign qs = neg_ff ? 24'(-mag_ff) : mag_ff;
   assign quotient = qs[15:0];
   assign busy = busy_ff;
   assign done = done_ff;
endmodule

[sim/tb_thermistor_linearize_scan_stats_top.sv]
// self-checking testbench for the thermistor linearizer with per-scan statistics
`timescale 1ns / 1ps
module tb_thermistor_linearize_scan_stats_top
   import tls_pkg::*;
();

   localparam int NCH = 88;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [6:0]  channel_index;
      logic [15:0] adc_code;
      logic        last_of_scan;
   } sample_type;

   typedef struct packed {
      logic signed [15:0] temperature;
      logic               reading_held;
      logic               channel_ignored;
      logic               scan_done;
      logic signed [15:0] scan_min;
      logic signed [15:0] scan_max;
      logic signed [15:0] scan_average;
      logic [6:0]         valid_count;
      logic [6:0]         ignored_count;
      logic               no_valid_channels;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [6:0] req_channel_index = '0;
   logic [15:0] req_adc_code = '0;
   logic req_last_of_scan = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_temperature, rsp_scan_min, rsp_scan_max, rsp_scan_average;
   logic rsp_reading_held, rsp_channel_ignored, rsp_scan_done, rsp_no_valid_channels;
   logic [6:0] rsp_valid_count, rsp_ignored_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_VVL;
   logic [15:0] csr_data = '0;

   thermistor_linearize_scan_stats_top #(.NUM_CHANNELS(NCH)) DUT (.*);

   // predictor state
   logic signed [15:0] volt_lo, volt_hi, temp_lo, temp_hi;
   logic signed [15:0] chan_temp [0:NCH-1];
   logic signed [15:0] run_min, run_max;
   logic signed [23:0] run_sum;
   logic [6:0] used_n, skipped_n;

   sample_type pending_samples[$];
   reading_type expected_readings[$];
   int send_idle_pct = 0, recv_stall_pct = 0;
   int errors = 0;
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int node_volt(int k);
      int t [0:32] = '{4160, 4192, 4224, 4256, 4288, 4320, 4384, 4416, 4480, 4576, 4640,
         4736, 4832, 4960, 5088, 5216, 5376, 5568, 5760, 5952, 6144, 6368, 6560, 6752,
         6944, 7136, 7264, 7424, 7520, 7616, 7680, 7744, 7808};
      return t[k];
   endfunction

   function automatic int interp_temp(int v);
      int lo, hi, d;
      if (v < node_volt(0)) return 30720;
      if (v > node_volt(32)) return 30720 - 1280 * 32;
      for (int k = 0; k < 32; k++) begin
         lo = node_volt(k);
         hi = node_volt(k + 1);
         if (v >= lo && v <= hi) begin
            d = hi - lo;
            return 30720 - 1280 * k - (1280 * (v - lo) + d / 2) / d;
         end
      end
      return 30720 - 1280 * 32;
   endfunction

   function automatic void restart_scan();
      run_min = temp_hi;
      run_max = temp_lo;
      run_sum = '0;
      used_n = '0;
      skipped_n = '0;
   endfunction

   function automatic reading_type predict_reading(sample_type s);
      reading_type r;
      int v, t, prev;
      bit have, held, ign;
      r = '0;
      have = s.channel_index < NCH;
      prev = have ? int'(chan_temp[s.channel_index]) : 0;
      v = int'(s.adc_code) - 32768;
      held = (v < volt_lo) || (v > volt_hi);
      t = held ? prev : interp_temp(v);
      ign = (t < temp_lo) || (t > temp_hi);
      if (have) chan_temp[s.channel_index] = 16'(t);
      if (ign) begin
         if (skipped_n < COUNT_MAX) skipped_n++;
      end else begin
         if (t < run_min) run_min = 16'(t);
         if (t > run_max) run_max = 16'(t);
         if (used_n < COUNT_MAX) begin
            run_sum = run_sum + 24'(t);
            used_n++;
         end
      end
      r.temperature = 16'(t);
      r.reading_held = held;
      r.channel_ignored = ign;
      if (s.last_of_scan) begin
         r.scan_done = 1'b1;
         r.scan_min = run_min;
         r.scan_max = run_max;
         r.scan_average = (used_n == 0) ? 16'sd0 : 16'(int'(run_sum) / int'(used_n));
         r.valid_count = used_n;
         r.ignored_count = skipped_n;
         r.no_valid_channels = (used_n == 0);
         restart_scan();
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            sample_type s;
            s = pending_samples.pop_front();
            expected_readings.push_back(predict_reading(s));
            req_valid <= 1'b1;
            req_channel_index <= s.channel_index;
            req_adc_code <= s.adc_code;
            req_last_of_scan <= s.last_of_scan;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            reading_type got, want;
            got = '{rsp_temperature, rsp_reading_held, rsp_channel_ignored, rsp_scan_done,
               rsp_scan_min, rsp_scan_max, rsp_scan_average, rsp_valid_count,
               rsp_ignored_count, rsp_no_valid_channels};
            if (expected_readings.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected transaction %p", got);
            end else begin
               want = expected_readings.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   initial begin
      while (cycles < LIMIT) @(posedge clock);
      $display("tb_thermistor_linearize_scan_stats_top: errors");
      $finish;
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VVL: volt_lo = val;
         CSR_VVH: volt_hi = val;
         CSR_ITL: temp_lo = val;
         default: temp_hi = val;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || expected_readings.size() > 0 || req_valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [15:0] table_adc();
      return 16'(32768 + $urandom_range(4100, 7870));
   endfunction

   task automatic queue_scans(int n);
      int left, len;
      sample_type s;
      left = n;
      while (left > 0) begin
         len = $urandom_range(1, 12);
         if ($urandom_range(19) == 0) len = $urandom_range(60, 140);
         for (int i = 0; i < len && left > 0; i++, left--) begin
            s.channel_index = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                     : 7'($urandom_range(NCH - 1));
            case ($urandom_range(9))
               0: s.adc_code = 16'($urandom());
               1: s.adc_code = 16'(32768 + $urandom_range(0, 65535 - 32768 - 20000));
               default: s.adc_code = table_adc();
            endcase
            s.last_of_scan = (i == len - 1) || ($urandom_range(29) == 0);
            pending_samples.push_back(s);
         end
      end
   endtask

   task automatic queue_directed();
      logic [15:0] codes [0:11] = '{16'h0000, 16'hFFFF, 16'h8000, 16'(32768 + 4159),
         16'(32768 + 4160), 16'(32768 + 7808), 16'(32768 + 7809), 16'(32768 + 7790),
         16'(32768 - 640), 16'(32768 - 641), 16'(32768 + 11200), 16'(32768 + 11201)};
      sample_type s;
      for (int i = 0; i < 12; i++) begin
         s.channel_index = 7'(i);
         s.adc_code = codes[i];
         s.last_of_scan = (i == 5);
         pending_samples.push_back(s);
      end
      s = '{7'd127, 16'hFFFF, 1'b0}; pending_samples.push_back(s);
      s = '{7'd87, 16'(32768 + 5000), 1'b0}; pending_samples.push_back(s);
      s = '{7'd87, 16'h0000, 1'b1}; pending_samples.push_back(s);
      s = '{7'd1, 16'h0000, 1'b1}; pending_samples.push_back(s);
      // scan over 127 used samples to hit count saturation
      for (int i = 0; i < 130; i++) begin
         s = '{7'(i % NCH), 16'(32768 + 7000), i == 129};
         pending_samples.push_back(s);
      end
   endtask

   initial begin
      volt_lo = -16'sd640;
      volt_hi = 16'sd11200;
      temp_lo = -16'sd9984;
      temp_hi = 16'sd30464;
      for (int i = 0; i < NCH; i++) chan_temp[i] = '0;
      restart_scan();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      queue_directed();
      drain();
      // extremes, inverted and wide windows
      write_reg(CSR_VVL, 16'h8000);
      write_reg(CSR_VVH, 16'h7FFF);
      write_reg(CSR_ITL, 16'h8000);
      write_reg(CSR_ITH, 16'h7FFF);
      send_idle_pct = 80;
      queue_scans(170);
      drain();
      write_reg(CSR_VVL, 16'h7FFF);
      write_reg(CSR_VVH, 16'h8000);
      write_reg(CSR_ITL, 16'h7FFF);
      write_reg(CSR_ITH, 16'h8000);
      send_idle_pct = 0;
      recv_stall_pct = 80;
      queue_scans(100);
      drain();
      write_reg(CSR_VVL, 16'd4500);
      write_reg(CSR_VVH, 16'd7500);
      write_reg(CSR_ITL, 16'(-2560));
      write_reg(CSR_ITH, 16'd20000);
      send_idle_pct = 6;
      recv_stall_pct = 6;
      queue_scans(200);
      drain();
      write_reg(CSR_VVL, 16'(-640));
      write_reg(CSR_VVH, 16'd11200);
      write_reg(CSR_ITL, 16'(-9984));
      write_reg(CSR_ITH, 16'd30464);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      queue_scans(200);
      drain();
      if (errors == 0) begin
         $display("tb_thermistor_linearize_scan_stats_top: clean");
      end else begin
         $display("tb_thermistor_linearize_scan_stats_top: errors");
      end
      $finish;
   end
endmodule
